@@ hdl/assert_macros.svh @@
// Assertion helpers used by q6k_block_int8_dot.
// Each macro builds one labelled concurrent assertion on the rising clock
// edge, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define Q6K_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define Q6K_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/q6k_pkg.sv @@
// ----------------------------------------------------------------------------
// q6k_pkg
// Shared types, codes and single-precision float helpers for the 6-bit
// K-quant int8 dot product block.
// ----------------------------------------------------------------------------
package q6k_pkg;

   localparam int BlockElements = 256;
   localparam int NumLanes      = 4;

   // Item operation codes
   localparam logic [1:0] OP_SCALE  = 2'd0;
   localparam logic [1:0] OP_HEADER = 2'd1;
   localparam logic [1:0] OP_DATA   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [31:0] CanonNan = 32'h7fc0_0000;

   // Rounding datapath: value = m * 2^(e - 127 - RndPoint)
   localparam int RndWidth = 50;
   localparam int RndPoint = 46;

   typedef logic [RndWidth-1:0] wide_type;

   // Scale write towards one lane
   typedef struct packed {
      logic       en;
      logic [1:0] addr;
      logic [7:0] data;
   } scale_wr_type;

   // Float sequencer steps
   typedef struct packed {
      logic conv;
      logic mul1;
      logic mul2;
   } fpu_ctl_type;

   // Normalise, round to nearest even and pack a single
   function automatic logic [31:0] round_pack(input logic sign, input int e,
                                              input wide_type m);
      int          p;
      int          big_e;
      int          sh;
      wide_type    kept;
      wide_type    mask;
      logic        guard;
      logic        sticky;
      logic [40:0] bits;
      p = -1;
      for (int i = 0; i < RndWidth; i++) begin
         if (m[i]) p = i;
      end
      if (p < 0) return {sign, 31'd0};
      big_e  = e + p - RndPoint;
      sh     = p - 23;
      guard  = 1'b0;
      sticky = 1'b0;
      if (big_e < 1) begin
         sh    = sh + 1 - big_e;
         big_e = 0;
      end else begin
         big_e = big_e - 1;
      end
      if (sh <= 0) begin
         kept = m << (-sh);
      end else begin
         kept = (sh < RndWidth) ? (m >> sh) : '0;
         if (sh - 1 < RndWidth) begin
            guard  = m[sh-1];
            mask   = (wide_type'(1) << (sh - 1)) - wide_type'(1);
            sticky = |(m & mask);
         end else begin
            sticky = |m;
         end
      end
      bits = (41'(big_e) << 23) + 41'(kept[23:0]);
      if (guard && (sticky || bits[0])) bits = bits + 41'd1;
      if (bits >= 41'h0_7f80_0000) return {sign, 8'hff, 23'd0};
      return {sign, bits[30:0]};
   endfunction

   // Half to single, exact
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic       sign;
      logic [4:0] ex;
      logic [9:0] man;
      sign = h[15];
      ex   = h[14:10];
      man  = h[9:0];
      if (ex == 5'd0) return round_pack(sign, 149, wide_type'(man));
      if (ex == 5'd31) return {sign, 8'hff, man, 13'd0};
      return {sign, 8'(ex) + 8'd112, man, 13'd0};
   endfunction

   // Signed 32-bit integer to single
   function automatic logic [31:0] int_to_single(input logic [31:0] v);
      logic [31:0] mag;
      mag = v[31] ? (32'd0 - v) : v;
      return round_pack(v[31], 173, wide_type'(mag));
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sign;
      logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
      logic [23:0] ma, mb;
      logic [47:0] prod;
      int          ea, eb;
      sign   = a[31] ^ b[31];
      nan_a  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      nan_b  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      inf_a  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      inf_b  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      zero_a = (a[30:0] == 31'd0);
      zero_b = (b[30:0] == 31'd0);
      if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) return CanonNan;
      if (inf_a || inf_b) return {sign, 8'hff, 23'd0};
      ma   = {a[30:23] != 8'd0, a[22:0]};
      mb   = {b[30:23] != 8'd0, b[22:0]};
      ea   = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
      eb   = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
      prod = ma * mb;
      return round_pack(sign, ea + eb - 127, wide_type'(prod));
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic        nan_a, nan_b, inf_a, inf_b;
      logic [31:0] big, sml;
      logic [23:0] m_big, m_sml;
      int          e_big, e_sml, d;
      wide_type    x_big, x_sml, al, mask, m;
      logic        sign;
      nan_a = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      nan_b = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      inf_a = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      inf_b = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) return CanonNan;
      if (inf_a) return a;
      if (inf_b) return b;
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      m_big = {big[30:23] != 8'd0, big[22:0]};
      m_sml = {sml[30:23] != 8'd0, sml[22:0]};
      e_big = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
      e_sml = (sml[30:23] == 8'd0) ? 1 : int'(sml[30:23]);
      d     = e_big - e_sml;
      x_big = wide_type'(m_big) << 24;
      x_sml = wide_type'(m_sml) << 24;
      // align the smaller operand, folding lost bits into a sticky lsb
      if (d >= RndWidth) begin
         al = wide_type'(m_sml != 24'd0);
      end else begin
         mask = (wide_type'(1) << d) - wide_type'(1);
         al   = (x_sml >> d) | wide_type'(|(x_sml & mask));
      end
      if (a[31] == b[31]) m = x_big + al;
      else m = x_big - al;
      sign = big[31];
      if (m == '0) sign = a[31] & b[31];
      return round_pack(sign, e_big - 1, m);
   endfunction

endpackage

@@ hdl/q6k_lane.sv @@
// ----------------------------------------------------------------------------
// q6k_lane
// One weight lane: keeps its four sub-block scales and forms
// scale * weight * activation over two registered multiply stages.
// ----------------------------------------------------------------------------
module q6k_lane (
   input  logic                   clock,
   input  q6k_pkg::scale_wr_type  scale_wr,
   input  logic [1:0]             rd_addr,
   input  logic [5:0]             weight,
   input  logic signed [7:0]      act,
   output logic signed [22:0]     product
);
   import q6k_pkg::*;

   logic signed [7:0]  scale_ff [4];
   logic signed [14:0] part_ff, part_in;
   logic signed [7:0]  act_ff, act_in;
   logic signed [22:0] product_ff, product_in;

   // scale registers, no reset
   always_ff @(posedge clock) begin
      if (scale_wr.en) scale_ff[scale_wr.addr] <= scale_wr.data;
   end

   // stage one: scale * weight, stage two: times activation
   always_comb begin
      part_in    = 15'(scale_ff[rd_addr]) * 15'(signed'({1'b0, weight}));
      act_in     = act;
      product_in = 23'(part_ff) * 23'(act_ff);
   end

   always_ff @(posedge clock) begin
      part_ff    <= part_in;
      act_ff     <= act_in;
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ hdl/q6k_fpu.sv @@
// ----------------------------------------------------------------------------
// q6k_fpu
// Block fold arithmetic: converts the fp16 weight scale and the integer block sum, forms
// (d*dx)*v over two multiply steps and adds the term into the row sum.
// ----------------------------------------------------------------------------
module q6k_fpu (
   input  logic                 clock,
   input  q6k_pkg::fpu_ctl_type ctl,
   input  logic [15:0]          weight_scale,
   input  logic [31:0]          act_scale,
   input  logic [31:0]          block_diff,
   input  logic [31:0]          row_acc,
   output logic [31:0]          row_sum
);
   import q6k_pkg::*;

   logic [31:0] d_ff, d_in;
   logic [31:0] v_ff, v_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] term_ff, term_in;

   // both conversions share one step, then one float multiply per step
   always_comb begin
      d_in    = ctl.conv ? half_to_single(weight_scale) : d_ff;
      v_in    = ctl.conv ? int_to_single(block_diff) : v_ff;
      prod_in = ctl.mul1 ? fp_mul(d_ff, act_scale) : prod_ff;
      term_in = ctl.mul2 ? fp_mul(prod_ff, v_ff) : term_ff;
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      v_ff    <= v_in;
      prod_ff <= prod_in;
      term_ff <= term_in;
   end

   // NaN comes back canonical from the adder
   assign row_sum = fp_add(row_acc, term_ff);

endmodule

@@ hdl/q6k_block_int8_dot.sv @@
// ----------------------------------------------------------------------------
// q6k_block_int8_dot
// Dot product of 6-bit K-quant weight rows with int8 activations.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item: op 0 loads a scale and its group sum,
//   op 1 the fp16/fp32 block scales, op 2 four packed weights with four
//   activations, op 3 is ignored. rsp_ channel returns the fp32 row sum
//   after an op 2 item with end_of_row set.
//   Scale, header and no-op items leave the block idle; the next item is taken in
//   the following cycle. A data item occupies the block through two lane
//   multiply stages and the merge, and on the last slot of a block through
//   the fold, which runs conversion, two float multiplies and the float add in
//   turn on one shared unit. An end-of-row item then passes through the emit
//   state, which loads the result register.
//   req_stall is high while an item is in work. A waiting result does not
//   hold the block, but a second result waits until the first is taken.
//   Reset clears the accumulators, block scales, row sum and any pending
//   result; sub-block scales must be loaded before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module q6k_block_int8_dot #(
   parameter int BLOCK_ELEMENTS = q6k_pkg::BlockElements
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [5:0]         req_slot,
   input  logic signed [7:0]  req_scale_value,
   input  logic signed [15:0] req_group_sum,
   input  logic [15:0]        req_d_half,
   input  logic [31:0]        req_dx_single,
   input  logic [15:0]        req_low_bytes,
   input  logic [7:0]         req_high_byte,
   input  logic [31:0]        req_acts,
   input  logic               req_end_of_row,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_row_sum_bits
);
   import q6k_pkg::*;

   localparam logic [5:0] LastSlot = 6'((BLOCK_ELEMENTS / 4 - 1) % 64);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LANE1 = 4'd1;
   localparam logic [3:0] ST_LANE2 = 4'd2;
   localparam logic [3:0] ST_MERGE = 4'd3;
   localparam logic [3:0] ST_CONV  = 4'd4;
   localparam logic [3:0] ST_MUL1  = 4'd5;
   localparam logic [3:0] ST_MUL2  = 4'd6;
   localparam logic [3:0] ST_ADD   = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [31:0] bias_acc_ff, bias_acc_in;
   logic [31:0] dot_acc_ff, dot_acc_in;
   logic [15:0] weight_scale_ff, weight_scale_in;
   logic [31:0] act_scale_ff, act_scale_in;
   logic [31:0] row_acc_ff, row_acc_in;
   logic [5:0]  slot_ff, slot_in;
   logic [15:0] low_ff, low_in;
   logic [7:0]  high_ff, high_in;
   logic [31:0] acts_ff, acts_in;
   logic        eor_ff, eor_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               emit_go;
   logic signed [23:0] bias_prod;
   logic [31:0]        lane_sum;
   logic [31:0]        block_diff;
   logic [31:0]        row_sum;
   fpu_ctl_type        fpu_ctl;
   logic [5:0]         weight [NumLanes];
   logic signed [22:0] product [NumLanes];
   scale_wr_type       scale_wr [NumLanes];

   assign accept  = req_valid && !req_stall;
   assign emit_go = !rsp_valid_ff || !rsp_stall;

   // unpack the four 6-bit weights of the held item
   always_comb begin
      weight[0] = {high_ff[1:0], low_ff[3:0]};
      weight[1] = {high_ff[3:2], low_ff[11:8]};
      weight[2] = {high_ff[5:4], low_ff[7:4]};
      weight[3] = {high_ff[7:6], low_ff[15:12]};
   end

   // lanes, each owns the scales for one weight position
   for (genvar k = 0; k < NumLanes; k++) begin : g_lane
      always_comb begin
         scale_wr[k].en   = accept && (req_op == OP_SCALE) && (req_slot[2:1] == 2'(k));
         scale_wr[k].addr = {req_slot[3], req_slot[0]};
         scale_wr[k].data = req_scale_value;
      end

      q6k_lane u_lane (
         .clock    (clock),
         .scale_wr (scale_wr[k]),
         .rd_addr  (slot_ff[5:4]),
         .weight   (weight[k]),
         .act      (signed'(acts_ff[8*k +: 8])),
         .product  (product[k])
      );
   end

   // merge the lane products
   always_comb begin
      lane_sum = 32'd0;
      for (int k = 0; k < NumLanes; k++) begin
         lane_sum = lane_sum + {{9{product[k][22]}}, product[k]};
      end
   end

   assign bias_prod  = req_scale_value * req_group_sum;
   assign block_diff = dot_acc_ff - {bias_acc_ff[26:0], 5'd0};

   always_comb begin
      fpu_ctl.conv = (state_ff == ST_CONV);
      fpu_ctl.mul1 = (state_ff == ST_MUL1);
      fpu_ctl.mul2 = (state_ff == ST_MUL2);
   end

   q6k_fpu u_fpu (
      .clock        (clock),
      .ctl          (fpu_ctl),
      .weight_scale (weight_scale_ff),
      .act_scale    (act_scale_ff),
      .block_diff   (block_diff),
      .row_acc      (row_acc_ff),
      .row_sum      (row_sum)
   );

   // sequencer and accumulators
   always_comb begin
      state_in        = state_ff;
      bias_acc_in     = bias_acc_ff;
      dot_acc_in      = dot_acc_ff;
      weight_scale_in = weight_scale_ff;
      act_scale_in    = act_scale_ff;
      row_acc_in      = row_acc_ff;
      slot_in         = slot_ff;
      low_in          = low_ff;
      high_in         = high_ff;
      acts_in         = acts_ff;
      eor_in          = eor_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_SCALE: bias_acc_in = bias_acc_ff + {{8{bias_prod[23]}}, bias_prod};
                  OP_HEADER: begin
                     weight_scale_in = req_d_half;
                     act_scale_in    = req_dx_single;
                  end
                  OP_DATA: begin
                     slot_in  = req_slot;
                     low_in   = req_low_bytes;
                     high_in  = req_high_byte;
                     acts_in  = req_acts;
                     eor_in   = req_end_of_row;
                     state_in = ST_LANE1;
                  end
                  default: ;
               endcase
            end
         end
         ST_LANE1: state_in = ST_LANE2;
         ST_LANE2: state_in = ST_MERGE;
         ST_MERGE: begin
            dot_acc_in = dot_acc_ff + lane_sum;
            if (slot_ff == LastSlot) state_in = ST_CONV;
            else if (eor_ff) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_CONV: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_ADD;
         ST_ADD: begin
            row_acc_in  = row_sum;
            dot_acc_in  = 32'd0;
            bias_acc_in = 32'd0;
            state_in    = eor_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = row_acc_ff;
               row_acc_in   = 32'd0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         bias_acc_ff     <= 32'd0;
         dot_acc_ff      <= 32'd0;
         weight_scale_ff <= 16'd0;
         act_scale_ff    <= 32'd0;
         row_acc_ff      <= 32'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bias_acc_ff     <= bias_acc_in;
         dot_acc_ff      <= dot_acc_in;
         weight_scale_ff <= weight_scale_in;
         act_scale_ff    <= act_scale_in;
         row_acc_ff      <= row_acc_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // item payload and result register
   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      low_ff      <= low_in;
      high_ff     <= high_in;
      acts_ff     <= acts_in;
      eor_ff      <= eor_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_sum_bits = rsp_data_ff;

   `Q6K_ASSERT_NEXT(a_fold_clears, state_ff == ST_ADD, (dot_acc_ff == 32'd0) && (bias_acc_ff == 32'd0), "fold did not clear block accumulators")
   `Q6K_ASSERT_NEXT(a_emit_clears, (state_ff == ST_EMIT) && emit_go, (row_acc_ff == 32'd0) && rsp_valid_ff, "emit did not clear row sum")
   `Q6K_ASSERT_NEXT(a_data_starts, accept && (req_op == OP_DATA), state_ff == ST_LANE1, "data item did not enter lanes")

endmodule
